// ----- hw/rtl/lolt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lolt_pkg;

    localparam int LBL_W       = 13;
    localparam int CNT_W       = 32;
    localparam int DEG_W       = 11;
    localparam int USED_W      = 11;
    localparam int PAIR_DEPTH  = 1024;
    localparam int PAIR_AW     = 10;
    localparam int LBL_DEPTH   = 4097;
    localparam int LBL_AW      = 13;
    localparam int KEY_W       = 2 * LBL_W;
    localparam int SCORE_W     = 17;
    localparam int QUOT_W      = 16;
    localparam int PAIR_WORD_W = 2 * LBL_W + CNT_W;
    localparam int LBL_WORD_W  = DEG_W + CNT_W;

    localparam logic [LBL_W-1:0]   MAX_LABEL  = 13'd4096;
    localparam logic [LBL_W-1:0]   SLOTS_RST  = 13'd4097;
    localparam logic [USED_W-1:0]  MAX_PAIRS  = 11'd1024;
    localparam logic [CNT_W-1:0]   COUNT_MAX  = 32'hFFFF_FFFF;
    localparam logic [SCORE_W-1:0] SCORE_ONE  = 17'h10000;

    typedef enum logic [1:0] {
        REQ_VOXEL = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_RANGE = 2'd1,
        STS_FULL  = 2'd2,
        STS_OVF   = 2'd3
    } t_status;

    typedef enum logic {
        REG_PREV_SLOTS = 1'b0,
        REG_CURR_SLOTS = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_V_CHK,
        ST_V_LBL,
        ST_SCAN,
        ST_V_UPD,
        ST_R_LBL1,
        ST_R_LBL2,
        ST_R_DIV,
        ST_EMIT,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [LBL_W-1:0] prev_label;
        logic [LBL_W-1:0] curr_label;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [LBL_W-1:0]   pair_prev;
        logic [LBL_W-1:0]   pair_curr;
        logic [CNT_W-1:0]   overlap_count;
        logic               is_continued;
        logic               is_split;
        logic               is_merged;
        logic [SCORE_W-1:0] score;
        logic               done_res;
    } t_out_item;

endpackage
`default_nettype wire

// ----- hw/rtl/label_overlap_lineage_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Voxel transaction: range check, label read, then an optional pair scan (linear scan of the
//   pair RAM, one entry per cycle) and the update; read transaction: pair scan, label reads
//   and an optional divider pass; clear transaction: zeroes the label RAMs in a pass.
// One transaction in flight; the next is taken in the idle state after the result is loaded.
// Reset: synchronous, active low; a clearing pass over every label address zeroes the label
//   RAMs and holds off input transactions, while configuration writes are taken as ever.
module label_overlap_lineage_table (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire lolt_pkg::t_in_item    i_in_data,
    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output lolt_pkg::t_out_item        o_out_data,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready
);
    localparam int LW = lolt_pkg::LBL_W;
    localparam int CW = lolt_pkg::CNT_W;
    localparam int DW = lolt_pkg::DEG_W;
    localparam int KEY_HI = lolt_pkg::KEY_W - 1;

    lolt_pkg::t_state    r_state, n_state;
    logic [LW-1:0]       r_prev_slots, r_curr_slots;

    // current transaction
    lolt_pkg::t_req      r_req;
    logic [LW-1:0]       r_p, r_c;
    lolt_pkg::t_out_item r_res;

    // frame state
    logic [lolt_pkg::USED_W-1:0] r_used;
    logic [lolt_pkg::KEY_W-1:0]  r_last;

    // pair scan
    logic [lolt_pkg::USED_W-1:0]  r_scan_cnt;
    logic                         r_cmp_vld;
    logic [lolt_pkg::PAIR_AW-1:0] r_cmp_idx;
    logic                         r_found;
    logic [lolt_pkg::PAIR_AW-1:0] r_fidx;
    logic [CW-1:0]                r_fcnt;
    logic                         r_have;
    logic [lolt_pkg::KEY_W-1:0]   r_best_key;
    logic [CW-1:0]                r_best_cnt;
    logic [CW-1:0]                r_ov;

    // clearing pass
    logic [lolt_pkg::LBL_AW-1:0]  r_clr_addr;
    logic                         r_clr_req;

    logic                         r_out_valid;
    lolt_pkg::t_out_item          r_out;

    // RAM ports
    logic                             pair_we;
    logic [lolt_pkg::PAIR_AW-1:0]     pair_waddr;
    logic [lolt_pkg::PAIR_WORD_W-1:0] pair_wdata, pair_rdata;
    logic                             pl_we, cl_we;
    logic [lolt_pkg::LBL_AW-1:0]      pl_waddr, cl_waddr;
    logic [lolt_pkg::LBL_WORD_W-1:0]  pl_wdata, cl_wdata, pl_rdata, cl_rdata;

    logic                     div_start, div_done;
    logic [lolt_pkg::QUOT_W-1:0] div_quot;

    // decoded fields
    logic [LW-1:0] rd_p, rd_c;
    logic [CW-1:0] rd_cnt;
    logic [lolt_pkg::KEY_W-1:0] rd_key;
    logic [DW-1:0] pdeg, cdeg;
    logic [CW-1:0] ptot, ctot;

    logic in_acc, emit_go, scan_issue, cmp_hit, key_better, scan_end;
    logic range_err, tot_err, pc, cnt_err, full_err, upd_ok, new_pair;
    logic cont;
    logic [CW-1:0] rest;
    logic [CW:0]   uni;
    logic          need_div, score_one;

    assign rd_p   = pair_rdata[lolt_pkg::PAIR_WORD_W-1 -: LW];
    assign rd_c   = pair_rdata[CW +: LW];
    assign rd_cnt = pair_rdata[CW-1:0];
    assign rd_key = {rd_c, rd_p};
    assign pdeg   = pl_rdata[CW +: DW];
    assign ptot   = pl_rdata[CW-1:0];
    assign cdeg   = cl_rdata[CW +: DW];
    assign ctot   = cl_rdata[CW-1:0];

    assign in_acc  = i_in_valid && o_in_ready;
    assign emit_go = !r_out_valid || i_out_ready;

    // scan: address issued one cycle, entry compared the next
    assign scan_issue = r_scan_cnt < r_used;
    assign cmp_hit    = r_cmp_vld && rd_p == r_p && rd_c == r_c;
    assign key_better = r_cmp_vld && rd_key > r_last && (!r_have || rd_key < r_best_key);
    assign scan_end   = (r_req == lolt_pkg::REQ_READ)
                        ? (!r_cmp_vld && !scan_issue)
                        : (cmp_hit || (!r_cmp_vld && !scan_issue));

    assign range_err = r_p >= r_prev_slots || r_p > lolt_pkg::MAX_LABEL ||
                       r_c >= r_curr_slots || r_c > lolt_pkg::MAX_LABEL;
    assign tot_err   = (r_p != '0 && ptot == lolt_pkg::COUNT_MAX) ||
                       (r_c != '0 && ctot == lolt_pkg::COUNT_MAX);
    assign pc        = r_p != '0 && r_c != '0;
    assign cnt_err   = r_found && r_fcnt == lolt_pkg::COUNT_MAX;
    assign full_err  = !r_found && r_used == lolt_pkg::MAX_PAIRS;
    assign upd_ok    = !(pc && (cnt_err || full_err));
    assign new_pair  = pc && !r_found;

    // score path for a read transaction
    assign cont      = r_ov == ptot && r_ov == ctot && pdeg == DW'(1) && cdeg == DW'(1);
    assign rest      = (ctot >= r_ov) ? ctot - r_ov : '0;
    assign uni       = {1'b0, ptot} + {1'b0, rest};
    assign score_one = (!uni[CW] && r_ov > uni[CW-1:0]) || uni == {1'b0, r_ov};
    assign need_div  = !cont && uni != '0 && !score_one;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lolt_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (lolt_pkg::t_req'(i_in_data.req_type))
                        lolt_pkg::REQ_VOXEL: n_state = lolt_pkg::ST_V_CHK;
                        lolt_pkg::REQ_READ:  n_state = lolt_pkg::ST_SCAN;
                        lolt_pkg::REQ_CLEAR: n_state = lolt_pkg::ST_CLEAR;
                        default:             n_state = lolt_pkg::ST_EMIT;
                    endcase
                end
            end
            lolt_pkg::ST_V_CHK: begin
                n_state = range_err ? lolt_pkg::ST_EMIT : lolt_pkg::ST_V_LBL;
            end
            lolt_pkg::ST_V_LBL: begin
                if (tot_err) begin
                    n_state = lolt_pkg::ST_EMIT;
                end else if (pc) begin
                    n_state = lolt_pkg::ST_SCAN;
                end else begin
                    n_state = lolt_pkg::ST_V_UPD;
                end
            end
            lolt_pkg::ST_SCAN: begin
                if (scan_end) begin
                    if (r_req == lolt_pkg::REQ_READ) begin
                        n_state = r_have ? lolt_pkg::ST_R_LBL1 : lolt_pkg::ST_EMIT;
                    end else begin
                        n_state = lolt_pkg::ST_V_UPD;
                    end
                end
            end
            lolt_pkg::ST_V_UPD:  n_state = lolt_pkg::ST_EMIT;
            lolt_pkg::ST_R_LBL1: n_state = lolt_pkg::ST_R_LBL2;
            lolt_pkg::ST_R_LBL2: n_state = need_div ? lolt_pkg::ST_R_DIV : lolt_pkg::ST_EMIT;
            lolt_pkg::ST_R_DIV: begin
                if (div_done) begin
                    n_state = lolt_pkg::ST_EMIT;
                end
            end
            lolt_pkg::ST_EMIT: begin
                if (emit_go) begin
                    n_state = lolt_pkg::ST_IDLE;
                end
            end
            lolt_pkg::ST_CLEAR: begin
                if (r_clr_addr == lolt_pkg::MAX_LABEL) begin
                    n_state = r_clr_req ? lolt_pkg::ST_EMIT : lolt_pkg::ST_IDLE;
                end
            end
            default: n_state = lolt_pkg::ST_IDLE;
        endcase
    end

    // outputs and RAM controls
    always_comb begin
        o_in_ready = r_state == lolt_pkg::ST_IDLE;
        div_start  = r_state == lolt_pkg::ST_R_LBL2 && need_div;
        pair_we    = r_state == lolt_pkg::ST_V_UPD && pc && upd_ok;
        pair_waddr = r_found ? r_fidx : r_used[lolt_pkg::PAIR_AW-1:0];
        pair_wdata = {r_p, r_c, (r_found ? r_fcnt + CW'(1) : CW'(1))};
        pl_we      = 1'b0;
        cl_we      = 1'b0;
        pl_waddr   = r_p;
        cl_waddr   = r_c;
        pl_wdata   = {pdeg + DW'(new_pair), ptot + CW'(1)};
        cl_wdata   = {cdeg + DW'(new_pair), ctot + CW'(1)};
        case (r_state)
            lolt_pkg::ST_CLEAR: begin
                pl_we    = 1'b1;
                cl_we    = 1'b1;
                pl_waddr = r_clr_addr;
                cl_waddr = r_clr_addr;
                pl_wdata = '0;
                cl_wdata = '0;
            end
            lolt_pkg::ST_V_UPD: begin
                pl_we = upd_ok && r_p != '0;
                cl_we = upd_ok && r_c != '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lolt_pkg::ST_CLEAR;
            r_prev_slots <= lolt_pkg::SLOTS_RST;
            r_curr_slots <= lolt_pkg::SLOTS_RST;
            r_used       <= '0;
            r_last       <= '0;
            r_clr_addr   <= '0;
            r_clr_req    <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            // configuration writes
            if (psel && penable && pwrite) begin
                if (paddr[2] == lolt_pkg::REG_CURR_SLOTS) begin
                    r_curr_slots <= pwdata[LW-1:0];
                end else begin
                    r_prev_slots <= pwdata[LW-1:0];
                end
            end

            // result register: load from the finished transaction, else drain
            if (r_state == lolt_pkg::ST_EMIT && emit_go) begin
                r_out_valid <= 1'b1;
                r_out       <= r_res;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // start of a scan
            if (r_state != lolt_pkg::ST_SCAN && n_state == lolt_pkg::ST_SCAN) begin
                r_scan_cnt <= '0;
                r_cmp_vld  <= 1'b0;
                r_found    <= 1'b0;
                r_have     <= 1'b0;
            end

            case (r_state)
                lolt_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        r_req <= lolt_pkg::t_req'(i_in_data.req_type);
                        r_p   <= i_in_data.prev_label;
                        r_c   <= i_in_data.curr_label;
                        r_res <= '0;
                        if (lolt_pkg::t_req'(i_in_data.req_type) == lolt_pkg::REQ_CLEAR) begin
                            r_clr_addr <= '0;
                            r_clr_req  <= 1'b1;
                            r_used     <= '0;
                            r_last     <= '0;
                        end
                    end
                end
                lolt_pkg::ST_V_CHK: begin
                    if (range_err) begin
                        r_res.status <= lolt_pkg::STS_RANGE;
                    end
                    r_found <= 1'b0;
                end
                lolt_pkg::ST_V_LBL: begin
                    if (tot_err) begin
                        r_res.status <= lolt_pkg::STS_OVF;
                    end
                end
                lolt_pkg::ST_SCAN: begin
                    r_cmp_vld <= scan_issue && !scan_end;
                    if (scan_issue) begin
                        r_scan_cnt <= r_scan_cnt + lolt_pkg::USED_W'(1);
                    end
                    r_cmp_idx <= r_scan_cnt[lolt_pkg::PAIR_AW-1:0];
                    if (r_req == lolt_pkg::REQ_READ) begin
                        if (key_better) begin
                            r_have     <= 1'b1;
                            r_best_key <= rd_key;
                            r_best_cnt <= rd_cnt;
                        end
                        if (scan_end) begin
                            if (r_have) begin
                                r_last <= r_best_key;
                                r_c    <= r_best_key[KEY_HI:LW];
                                r_p    <= r_best_key[LW-1:0];
                                r_ov   <= r_best_cnt;
                            end else begin
                                r_res.done_res <= 1'b1;
                            end
                        end
                    end else if (cmp_hit) begin
                        r_found <= 1'b1;
                        r_fidx  <= r_cmp_idx;
                        r_fcnt  <= rd_cnt;
                    end
                end
                lolt_pkg::ST_V_UPD: begin
                    if (pc && cnt_err) begin
                        r_res.status <= lolt_pkg::STS_OVF;
                    end else if (pc && full_err) begin
                        r_res.status <= lolt_pkg::STS_FULL;
                    end else if (new_pair) begin
                        r_used <= r_used + lolt_pkg::USED_W'(1);
                    end
                end
                lolt_pkg::ST_R_LBL2: begin
                    r_res.pair_prev     <= r_p;
                    r_res.pair_curr     <= r_c;
                    r_res.overlap_count <= r_ov;
                    if (cont) begin
                        r_res.is_continued <= 1'b1;
                        r_res.score        <= lolt_pkg::SCORE_ONE;
                    end else begin
                        r_res.is_split  <= pdeg > DW'(1);
                        r_res.is_merged <= cdeg > DW'(1);
                        if (uni != '0 && score_one) begin
                            r_res.score <= lolt_pkg::SCORE_ONE;
                        end
                    end
                end
                lolt_pkg::ST_R_DIV: begin
                    if (div_done) begin
                        r_res.score <= {1'b0, div_quot};
                    end
                end
                lolt_pkg::ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + lolt_pkg::LBL_AW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == lolt_pkg::REG_CURR_SLOTS)
                         ? {19'd0, r_curr_slots} : {19'd0, r_prev_slots};

    // pair table: {prev, curr, overlap}
    lolt_ram #(
        .W (lolt_pkg::PAIR_WORD_W),
        .D (lolt_pkg::PAIR_DEPTH),
        .AW(lolt_pkg::PAIR_AW)
    ) u_pair_ram (
        .i_clk  (i_clk),
        .i_we   (pair_we),
        .i_waddr(pair_waddr),
        .i_wdata(pair_wdata),
        .i_raddr(r_scan_cnt[lolt_pkg::PAIR_AW-1:0]),
        .o_rdata(pair_rdata)
    );

    // per-label {degree, total}
    lolt_ram #(
        .W (lolt_pkg::LBL_WORD_W),
        .D (lolt_pkg::LBL_DEPTH),
        .AW(lolt_pkg::LBL_AW)
    ) u_prev_ram (
        .i_clk  (i_clk),
        .i_we   (pl_we),
        .i_waddr(pl_waddr),
        .i_wdata(pl_wdata),
        .i_raddr(r_p),
        .o_rdata(pl_rdata)
    );

    lolt_ram #(
        .W (lolt_pkg::LBL_WORD_W),
        .D (lolt_pkg::LBL_DEPTH),
        .AW(lolt_pkg::LBL_AW)
    ) u_curr_ram (
        .i_clk  (i_clk),
        .i_we   (cl_we),
        .i_waddr(cl_waddr),
        .i_wdata(cl_wdata),
        .i_raddr(r_c),
        .o_rdata(cl_rdata)
    );

    lolt_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (r_ov),
        .i_den  (uni),
        .o_done (div_done),
        .o_quot (div_quot)
    );
endmodule
`default_nettype wire

// ----- hw/rtl/lolt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lolt_ram #(
    parameter int W  = 8,
    parameter int D  = 16,
    parameter int AW = $clog2(D)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/lolt_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lolt_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [lolt_pkg::CNT_W-1:0]    i_num,
    input  wire logic [lolt_pkg::CNT_W:0]      i_den,
    output logic                               o_done,
    output logic      [lolt_pkg::QUOT_W-1:0]   o_quot
);
    logic [lolt_pkg::CNT_W+1:0]  r_rem;
    logic [lolt_pkg::CNT_W:0]    r_den;
    logic [4:0]                  r_cnt;
    logic [lolt_pkg::CNT_W+1:0]  w_sh;
    logic                        w_ge;

    assign w_sh = {r_rem[lolt_pkg::CNT_W:0], 1'b0};
    assign w_ge = w_sh >= {1'b0, r_den};

    // restoring divide, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_rem <= {2'b00, i_num};
                r_den <= i_den;
                r_cnt <= 5'(lolt_pkg::QUOT_W);
            end else if (r_cnt != '0) begin
                if (w_ge) begin
                    r_rem <= w_sh - {1'b0, r_den};
                end else begin
                    r_rem <= w_sh;
                end
                o_quot <= {o_quot[lolt_pkg::QUOT_W-2:0], w_ge};
                r_cnt  <= r_cnt - 5'd1;
                o_done <= (r_cnt == 5'd1);
            end
        end
    end
endmodule
`default_nettype wire

// ----- tb/tb_label_overlap_lineage_table.sv -----
`timescale 1ns / 1ps

// Scoreboard: keeps a private copy of the overlap table, predicts every
// result on input acceptance and checks results in order.
class lineage_scoreboard;
    bit [12:0]           slots_prev;
    bit [12:0]           slots_curr;
    bit [12:0]           tab_prev [1024];
    bit [12:0]           tab_curr [1024];
    longint unsigned     tab_cnt  [1024];
    int                  tab_used;
    int                  deg_prev [4097];
    int                  deg_curr [4097];
    longint unsigned     tot_prev [4097];
    longint unsigned     tot_curr [4097];
    int unsigned         read_key;
    lolt_pkg::t_out_item expected_q [$];
    int                  errors;

    function void wipe();
        tab_used = 0;
        read_key = 0;
        for (int i = 0; i < 4097; i++) begin
            deg_prev[i] = 0;
            deg_curr[i] = 0;
            tot_prev[i] = 0;
            tot_curr[i] = 0;
        end
    endfunction

    function void init();
        slots_prev = 13'd4097;
        slots_curr = 13'd4097;
        errors = 0;
        wipe();
    endfunction

    function lolt_pkg::t_status voxel(int p, int c);
        longint unsigned cmax;
        int idx;
        cmax = 64'hFFFF_FFFF;
        idx = -1;
        if (p >= slots_prev || p > 4096 || c >= slots_curr || c > 4096)
            return lolt_pkg::STS_RANGE;
        if ((p != 0 && tot_prev[p] >= cmax) || (c != 0 && tot_curr[c] >= cmax))
            return lolt_pkg::STS_OVF;
        if (p != 0 && c != 0) begin
            for (int i = 0; i < tab_used; i++)
                if (tab_prev[i] == p && tab_curr[i] == c) begin
                    idx = i;
                    break;
                end
            if (idx >= 0 && tab_cnt[idx] >= cmax) return lolt_pkg::STS_OVF;
            if (idx < 0 && tab_used >= 1024) return lolt_pkg::STS_FULL;
            if (idx >= 0) tab_cnt[idx]++;
            else begin
                tab_prev[tab_used] = 13'(p);
                tab_curr[tab_used] = 13'(c);
                tab_cnt[tab_used] = 1;
                tab_used++;
                deg_prev[p]++;
                deg_curr[c]++;
            end
        end
        if (p != 0) tot_prev[p]++;
        if (c != 0) tot_curr[c]++;
        return lolt_pkg::STS_OK;
    endfunction

    function lolt_pkg::t_out_item next_pair();
        lolt_pkg::t_out_item r;
        int best;
        int unsigned key, best_key;
        longint unsigned ov, pt, ct, uni;
        int p, c;
        r = '0;
        best = -1;
        best_key = 0;
        for (int i = 0; i < tab_used; i++) begin
            key = 32'({tab_curr[i], tab_prev[i]});
            if (key > read_key && (best < 0 || key < best_key)) begin
                best = i;
                best_key = key;
            end
        end
        if (best < 0) begin
            r.done_res = 1'b1;
            return r;
        end
        read_key = best_key;
        p = tab_prev[best];
        c = tab_curr[best];
        ov = tab_cnt[best];
        pt = tot_prev[p];
        ct = tot_curr[c];
        r.pair_prev = 13'(p);
        r.pair_curr = 13'(c);
        r.overlap_count = ov[31:0];
        if (ov == pt && ov == ct && deg_prev[p] == 1 && deg_curr[c] == 1) begin
            r.is_continued = 1'b1;
            r.score = lolt_pkg::SCORE_ONE;
            return r;
        end
        r.is_split = deg_prev[p] > 1;
        r.is_merged = deg_curr[c] > 1;
        uni = pt + ((ct >= ov) ? ct - ov : 0);
        if (uni == 0) r.score = '0;
        else if (ov >= uni) r.score = lolt_pkg::SCORE_ONE;
        else r.score = 17'((ov << 16) / uni);
        return r;
    endfunction

    // Predict the result of one accepted transaction.
    function void note_input(lolt_pkg::t_in_item it);
        lolt_pkg::t_out_item r;
        r = '0;
        case (it.req_type)
            lolt_pkg::REQ_VOXEL: r.status = voxel(it.prev_label, it.curr_label);
            lolt_pkg::REQ_READ:  r = next_pair();
            lolt_pkg::REQ_CLEAR: wipe();
            default:   ;
        endcase
        expected_q.insert(expected_q.size(), r);
    endfunction

    function void check(lolt_pkg::t_out_item act);
        lolt_pkg::t_out_item e;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, act);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (act.status != e.status)
            $display("%0t: status exp %0d act %0d", $time, e.status, act.status);
        if (act.pair_prev != e.pair_prev)
            $display("%0t: pair_prev exp %0d act %0d", $time, e.pair_prev, act.pair_prev);
        if (act.pair_curr != e.pair_curr)
            $display("%0t: pair_curr exp %0d act %0d", $time, e.pair_curr, act.pair_curr);
        if (act.overlap_count != e.overlap_count)
            $display("%0t: overlap exp %0d act %0d", $time, e.overlap_count,
                     act.overlap_count);
        if (act.is_continued != e.is_continued)
            $display("%0t: continued exp %0d act %0d", $time, e.is_continued,
                     act.is_continued);
        if (act.is_split != e.is_split)
            $display("%0t: split exp %0d act %0d", $time, e.is_split, act.is_split);
        if (act.is_merged != e.is_merged)
            $display("%0t: merged exp %0d act %0d", $time, e.is_merged, act.is_merged);
        if (act.score != e.score)
            $display("%0t: score exp %0d act %0d", $time, e.score, act.score);
        if (act.done_res != e.done_res)
            $display("%0t: done exp %0d act %0d", $time, e.done_res, act.done_res);
        if (act != e) errors++;
    endfunction
endclass

module tb_label_overlap_lineage_table;

    localparam int CYCLE_LIMIT = 30000000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    lolt_pkg::t_in_item  i_in_data;
    logic                o_out_valid;
    logic                i_out_ready;
    lolt_pkg::t_out_item o_out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    lineage_scoreboard sb;
    int  cycles;
    int  sent;
    bit  hold_req;     // ask the receiver for one long stall
    bit  hold_done;    // long stall already requested
    bit  in_burst;     // sender runs without gaps
    bit  out_burst;    // receiver runs without gaps
    int  lbl_cap;      // typical label span of the current frame

    label_overlap_lineage_table i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the block hangs.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("** label_overlap_lineage_table: FAILED **");
                $finish;
            end
        end
    end

    // Offer one transaction after a random gap; return once it is accepted.
    // Valid stays high after acceptance, so a zero gap keeps the stream dense.
    task automatic send(lolt_pkg::t_req req, int p, int c);
        int gap;
        lolt_pkg::t_in_item it;
        gap = in_burst ? 0 : $urandom_range(0, 8);
        it.req_type = req;
        it.prev_label = 13'(p);
        it.curr_label = 13'(c);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(it);
        sent++;
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle; register taken at the access edge.
    task automatic write_reg(lolt_pkg::t_reg_idx idx, int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        if (idx == lolt_pkg::REG_PREV_SLOTS) sb.slots_prev = 13'(value);
        else sb.slots_curr = 13'(value);
    endtask

    task automatic set_slots(int sp, int sc);
        drain();
        write_reg(lolt_pkg::REG_PREV_SLOTS, sp);
        write_reg(lolt_pkg::REG_CURR_SLOTS, sc);
    endtask

    // Mostly small labels inside the window, with boundary values and raw noise.
    function automatic int pick_label(int slots);
        int r, lim;
        r = $urandom_range(0, 99);
        lim = (slots > 0) ? slots - 1 : 0;
        if (lim > 4096) lim = 4096;
        if (lim > lbl_cap) lim = lbl_cap;
        if (r < 4) return $urandom_range(0, 8191);
        if (r < 7) begin
            case ($urandom_range(0, 3))
                0: return slots;
                1: return (slots > 0) ? slots - 1 : 0;
                2: return 4096;
                default: return 4097;
            endcase
        end
        return $urandom_range(0, lim);
    endfunction

    // Receiver: random stalls, dense stretches, and one long hold-off on request.
    initial begin
        int gap;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                gap = 400;
                hold_req = 1'b0;
            end else begin
                gap = out_burst ? 0 : $urandom_range(0, 8);
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check(o_out_data);
        end
    end

    initial begin
        int n, np, wait_cycles;
        lolt_pkg::t_req rq;
        sb = new();
        sb.init();
        sent = 0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        in_burst = 1'b0;
        out_burst = 1'b0;
        lbl_cap = 8;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty reads, range edges, background, split, merge, continuation.
        write_reg(lolt_pkg::REG_PREV_SLOTS, 4097);
        write_reg(lolt_pkg::REG_CURR_SLOTS, 4097);
        send(lolt_pkg::REQ_READ, 0, 0);
        send(lolt_pkg::REQ_VOXEL, 0, 0);
        send(lolt_pkg::REQ_VOXEL, 4096, 4096);
        send(lolt_pkg::REQ_VOXEL, 4097, 1);
        send(lolt_pkg::REQ_VOXEL, 1, 4097);
        send(lolt_pkg::REQ_VOXEL, 8191, 8191);
        send(lolt_pkg::REQ_VOXEL, 1, 0);
        send(lolt_pkg::REQ_VOXEL, 0, 1);
        send(lolt_pkg::REQ_VOXEL, 1, 1);
        send(lolt_pkg::REQ_VOXEL, 1, 1);
        send(lolt_pkg::REQ_VOXEL, 2, 1);
        send(lolt_pkg::REQ_VOXEL, 1, 2);
        send(lolt_pkg::REQ_VOXEL, 3, 3);
        send(lolt_pkg::REQ_NONE, 8191, 8191);
        repeat (3) send(lolt_pkg::REQ_READ, 0, 0);
        // Pair below the read cursor stays hidden until the next clear.
        send(lolt_pkg::REQ_VOXEL, 5, 1);
        repeat (4) send(lolt_pkg::REQ_READ, 0, 0);
        send(lolt_pkg::REQ_CLEAR, 0, 0);
        send(lolt_pkg::REQ_READ, 0, 0);

        // Zero slots: everything out of range.
        set_slots(0, 0);
        send(lolt_pkg::REQ_VOXEL, 0, 0);
        send(lolt_pkg::REQ_VOXEL, 1, 1);

        // Fill the pair table, then overflow it.
        set_slots(4097, 4097);
        send(lolt_pkg::REQ_CLEAR, 0, 0);
        in_burst = 1'b1;
        for (int i = 0; i < 1024; i++)
            send(lolt_pkg::REQ_VOXEL, (i % 32) + 1, (i / 32) + 1);
        in_burst = 1'b0;
        send(lolt_pkg::REQ_VOXEL, 4096, 4096);
        send(lolt_pkg::REQ_VOXEL, 33, 1);
        send(lolt_pkg::REQ_VOXEL, 1, 1);
        repeat (20) send(lolt_pkg::REQ_READ, 0, 0);
        send(lolt_pkg::REQ_CLEAR, 0, 0);

        // Random frames: clear, voxel stream, read-out, with noise mixed in.
        while (sent < 1600) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 7))
                    0: set_slots(4097, 4097);
                    1: set_slots(8, 8);
                    2: set_slots(1, 4097);
                    3: set_slots(0, 0);
                    4: set_slots(8191, 8191);
                    5: set_slots(4097, 5);
                    6: set_slots(5, 4097);
                    default: set_slots($urandom_range(1, 4097), $urandom_range(1, 4097));
                endcase
            end
            in_burst = ($urandom_range(0, 4) == 0);
            out_burst = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0: lbl_cap = 4096;
                1, 2: lbl_cap = 64;
                default: lbl_cap = 8;
            endcase
            if ($urandom_range(0, 1) == 0) send(lolt_pkg::REQ_CLEAR, 0, 0);
            if (!hold_done && sent > 1150) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            n = $urandom_range(5, 60);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    rq = lolt_pkg::t_req'($urandom_range(0, 3));
                    if (rq == lolt_pkg::REQ_CLEAR) rq = lolt_pkg::REQ_NONE;
                    send(rq, $urandom_range(0, 8191), $urandom_range(0, 8191));
                end else begin
                    send(lolt_pkg::REQ_VOXEL, pick_label(sb.slots_prev),
                         pick_label(sb.slots_curr));
                end
            end
            np = sb.tab_used + $urandom_range(0, 2);
            if (np > 40) np = 40;
            for (int k = 0; k < np; k++) send(lolt_pkg::REQ_READ, 0, 0);
            // Pause the sender until the block has answered everything.
            if ($urandom_range(0, 3) == 0) drain();
        end

        i_in_valid <= 1'b0;
        wait_cycles = 0;
        while (sb.expected_q.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("** label_overlap_lineage_table: PASSED **");
        end else begin
            $display("** label_overlap_lineage_table: FAILED **");
        end
        $finish;
    end

endmodule
